// ===== rtl/ccp_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle collision push-out package
// Shared widths and pair-kind codes for the collision pipeline.
// ----------------------------------------------------------------------------
package ccp_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int FRAC_BITS   = 12;

   localparam logic [1:0] CMD_CIRCLE_CIRCLE = 2'd0;
   localparam logic [1:0] CMD_CIRCLE_BOX    = 2'd1;

endpackage

// ===== rtl/ccp_front.sv =====
// ----------------------------------------------------------------------------
// Collision front end
// Forms the offset and extent, squares them and performs the hit test.
// ----------------------------------------------------------------------------
module ccp_front #(
   parameter int COORD_WIDTH = ccp_pkg::COORD_WIDTH,
   parameter int FRAC_BITS   = ccp_pkg::FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [1:0]                    cmd,
   input  logic signed [COORD_WIDTH-1:0] p_x,
   input  logic signed [COORD_WIDTH-1:0] p_y,
   input  logic [COORD_WIDTH-2:0]        p_radius,
   input  logic signed [COORD_WIDTH-1:0] q_x,
   input  logic signed [COORD_WIDTH-1:0] q_y,
   input  logic [COORD_WIDTH-2:0]        q_radius,
   input  logic signed [COORD_WIDTH-1:0] box_left,
   input  logic signed [COORD_WIDTH-1:0] box_right,
   input  logic signed [COORD_WIDTH-1:0] box_top,
   input  logic signed [COORD_WIDTH-1:0] box_bottom,
   output logic                          out_valid,
   output logic [2*COORD_WIDTH-1:0]      out_dsq,
   output logic                          out_hit,
   output logic                          out_near,
   output logic                          out_sx,
   output logic                          out_sy,
   output logic [COORD_WIDTH-1:0]        out_ax,
   output logic [COORD_WIDTH-1:0]        out_ay,
   output logic [COORD_WIDTH-1:0]        out_r
);

   localparam int W = COORD_WIDTH;
   localparam logic [63:0] NEAR_ZERO_SQ = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;

   logic signed [W-1:0] cx, cy;
   logic signed [W:0]   dx1_in, dy1_in;
   logic [W-1:0]        r1_in;
   logic                k1_in;

   logic                v1_ff, k1_ff;
   logic signed [W:0]   dx1_ff, dy1_ff;
   logic [W-1:0]        r1_ff;

   logic [W:0]          ax2_in, ay2_in;
   logic                v2_ff, k2_ff, sx2_ff, sy2_ff;
   logic [W:0]          ax2_ff, ay2_ff;
   logic [W-1:0]        r2_ff;

   logic [2*W+1:0]      sqx3_in, sqy3_in;
   logic [2*W-1:0]      rsq3_in;
   logic                v3_ff, k3_ff, sx3_ff, sy3_ff;
   logic [2*W+1:0]      sqx3_ff, sqy3_ff;
   logic [2*W-1:0]      rsq3_ff;
   logic [W:0]          ax3_ff, ay3_ff;
   logic [W-1:0]        r3_ff;

   logic [2*W+2:0]      dsq4_in;
   logic                hit4_in, near4_in;
   logic                v4_ff, hit4_ff, near4_ff, sx4_ff, sy4_ff;
   logic [2*W-1:0]      dsq4_ff;
   logic [W-1:0]        ax4_ff, ay4_ff, r4_ff;

   always_comb begin
      cx = (p_x < box_left) ? box_left : ((p_x > box_right) ? box_right : p_x);
      cy = (p_y < box_top) ? box_top : ((p_y > box_bottom) ? box_bottom : p_y);
      k1_in = (cmd == ccp_pkg::CMD_CIRCLE_CIRCLE) || (cmd == ccp_pkg::CMD_CIRCLE_BOX);
      if (cmd == ccp_pkg::CMD_CIRCLE_CIRCLE) begin
         dx1_in = {q_x[W-1], q_x} - {p_x[W-1], p_x};
         dy1_in = {q_y[W-1], q_y} - {p_y[W-1], p_y};
         r1_in  = {1'b0, p_radius} + {1'b0, q_radius};
      end else begin
         dx1_in = {p_x[W-1], p_x} - {cx[W-1], cx};
         dy1_in = {p_y[W-1], p_y} - {cy[W-1], cy};
         r1_in  = {1'b0, p_radius};
      end
   end

   assign ax2_in = dx1_ff[W] ? (~dx1_ff + 1'b1) : dx1_ff;
   assign ay2_in = dy1_ff[W] ? (~dy1_ff + 1'b1) : dy1_ff;

   assign sqx3_in = ax2_ff * ax2_ff;
   assign sqy3_in = ay2_ff * ay2_ff;
   assign rsq3_in = r2_ff * r2_ff;

   assign dsq4_in  = {1'b0, sqx3_ff} + {1'b0, sqy3_ff};
   assign hit4_in  = k3_ff && (dsq4_in <= {3'b000, rsq3_ff});
   assign near4_in = 64'(dsq4_in) <= NEAR_ZERO_SQ;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      k1_ff    <= k1_in;
      dx1_ff   <= dx1_in;
      dy1_ff   <= dy1_in;
      r1_ff    <= r1_in;
      k2_ff    <= k1_ff;
      sx2_ff   <= dx1_ff[W];
      sy2_ff   <= dy1_ff[W];
      ax2_ff   <= ax2_in;
      ay2_ff   <= ay2_in;
      r2_ff    <= r1_ff;
      k3_ff    <= k2_ff;
      sx3_ff   <= sx2_ff;
      sy3_ff   <= sy2_ff;
      sqx3_ff  <= sqx3_in;
      sqy3_ff  <= sqy3_in;
      rsq3_ff  <= rsq3_in;
      ax3_ff   <= ax2_ff;
      ay3_ff   <= ay2_ff;
      r3_ff    <= r2_ff;
      hit4_ff  <= hit4_in;
      near4_ff <= near4_in;
      sx4_ff   <= sx3_ff;
      sy4_ff   <= sy3_ff;
      dsq4_ff  <= dsq4_in[2*W-1:0];
      ax4_ff   <= ax3_ff[W-1:0];
      ay4_ff   <= ay3_ff[W-1:0];
      r4_ff    <= r3_ff;
   end

   assign out_valid = v4_ff;
   assign out_dsq   = dsq4_ff;
   assign out_hit   = hit4_ff;
   assign out_near  = near4_ff;
   assign out_sx    = sx4_ff;
   assign out_sy    = sy4_ff;
   assign out_ax    = ax4_ff;
   assign out_ay    = ay4_ff;
   assign out_r     = r4_ff;

endmodule

// ===== rtl/ccp_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Produces one root bit per stage; side data travels with each request.
// ----------------------------------------------------------------------------
module ccp_sqrt #(
   parameter int N      = ccp_pkg::COORD_WIDTH,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [2*N-1:0]    in_radicand,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [N-1:0]      out_root,
   output logic [SIDE_W-1:0] out_side
);

   logic              cur_v    [0:N-1];
   logic [N+1:0]      cur_rem  [0:N-1];
   logic [N-1:0]      cur_root [0:N-1];
   logic [2*N-1:0]    cur_rad  [0:N-1];
   logic [SIDE_W-1:0] cur_side [0:N-1];

   logic              v_ff    [1:N];
   logic [N+1:0]      rem_ff  [1:N];
   logic [N-1:0]      root_ff [1:N];
   logic [2*N-1:0]    rad_ff  [1:N];
   logic [SIDE_W-1:0] side_ff [1:N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [N+1:0]   shifted, trial, rem_in;
      logic [N-1:0]   root_in;
      logic [2*N-1:0] rad_in;
      logic           ge;

      if (k == 0) begin : g_first
         assign cur_v[k]    = in_valid;
         assign cur_rem[k]  = '0;
         assign cur_root[k] = '0;
         assign cur_rad[k]  = in_radicand;
         assign cur_side[k] = in_side;
      end else begin : g_next
         assign cur_v[k]    = v_ff[k];
         assign cur_rem[k]  = rem_ff[k];
         assign cur_root[k] = root_ff[k];
         assign cur_rad[k]  = rad_ff[k];
         assign cur_side[k] = side_ff[k];
      end

      assign shifted = {cur_rem[k][N-1:0], cur_rad[k][2*N-1:2*N-2]};
      assign trial   = {cur_root[k], 2'b01};
      assign ge      = shifted >= trial;
      assign rem_in  = ge ? (shifted - trial) : shifted;
      assign root_in = {cur_root[k][N-2:0], ge};
      assign rad_in  = {cur_rad[k][2*N-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= cur_v[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= rem_in;
         root_ff[k+1] <= root_in;
         rad_ff[k+1]  <= rad_in;
         side_ff[k+1] <= cur_side[k];
      end
   end

   assign out_valid = v_ff[N];
   assign out_root  = root_ff[N];
   assign out_side  = side_ff[N];

endmodule

// ===== rtl/ccp_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined dual divider
// Divides two numerators by one divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ccp_div #(
   parameter int N      = ccp_pkg::COORD_WIDTH,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [2*N-1:0]    in_num_a,
   input  logic [2*N-1:0]    in_num_b,
   input  logic [N-1:0]      in_divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [N-1:0]      out_quot_a,
   output logic [N-1:0]      out_quot_b,
   output logic [SIDE_W-1:0] out_side
);

   logic              cur_v    [0:N-1];
   logic [N-1:0]      cur_ra   [0:N-1];
   logic [N-1:0]      cur_rb   [0:N-1];
   logic [N-1:0]      cur_la   [0:N-1];
   logic [N-1:0]      cur_lb   [0:N-1];
   logic [N-1:0]      cur_d    [0:N-1];
   logic [SIDE_W-1:0] cur_side [0:N-1];

   logic              v_ff    [1:N];
   logic [N-1:0]      ra_ff   [1:N];
   logic [N-1:0]      rb_ff   [1:N];
   logic [N-1:0]      la_ff   [1:N];
   logic [N-1:0]      lb_ff   [1:N];
   logic [N-1:0]      d_ff    [1:N];
   logic [SIDE_W-1:0] side_ff [1:N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [N:0]   sha, shb;
      logic         gea, geb;
      logic [N:0]   ra_diff, rb_diff;
      logic [N-1:0] ra_in, rb_in, la_in, lb_in;

      if (k == 0) begin : g_first
         assign cur_v[k]    = in_valid;
         assign cur_ra[k]   = in_num_a[2*N-1:N];
         assign cur_rb[k]   = in_num_b[2*N-1:N];
         assign cur_la[k]   = in_num_a[N-1:0];
         assign cur_lb[k]   = in_num_b[N-1:0];
         assign cur_d[k]    = in_divisor;
         assign cur_side[k] = in_side;
      end else begin : g_next
         assign cur_v[k]    = v_ff[k];
         assign cur_ra[k]   = ra_ff[k];
         assign cur_rb[k]   = rb_ff[k];
         assign cur_la[k]   = la_ff[k];
         assign cur_lb[k]   = lb_ff[k];
         assign cur_d[k]    = d_ff[k];
         assign cur_side[k] = side_ff[k];
      end

      assign sha     = {cur_ra[k], cur_la[k][N-1]};
      assign shb     = {cur_rb[k], cur_lb[k][N-1]};
      assign gea     = sha >= {1'b0, cur_d[k]};
      assign geb     = shb >= {1'b0, cur_d[k]};
      assign ra_diff = sha - {1'b0, cur_d[k]};
      assign rb_diff = shb - {1'b0, cur_d[k]};
      assign ra_in   = gea ? ra_diff[N-1:0] : sha[N-1:0];
      assign rb_in   = geb ? rb_diff[N-1:0] : shb[N-1:0];
      assign la_in   = {cur_la[k][N-2:0], gea};
      assign lb_in   = {cur_lb[k][N-2:0], geb};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= cur_v[k];
         end
      end

      always_ff @(posedge clock) begin
         ra_ff[k+1]   <= ra_in;
         rb_ff[k+1]   <= rb_in;
         la_ff[k+1]   <= la_in;
         lb_ff[k+1]   <= lb_in;
         d_ff[k+1]    <= cur_d[k];
         side_ff[k+1] <= cur_side[k];
      end
   end

   assign out_valid  = v_ff[N];
   assign out_quot_a = la_ff[N];
   assign out_quot_b = lb_ff[N];
   assign out_side   = side_ff[N];

endmodule

// ===== rtl/circle_collision_pushout.sv =====
// Throughput: one request per cycle; busy stays low since every stage advances
// each cycle and the receiver cannot stall.
// The depth is set by the one-bit-per-stage square root and divider pipelines.
// Reset is synchronous and clears only the valid bits; no result follows it.
// ----------------------------------------------------------------------------
// Circle collision push-out
// Circle-circle and circle-box hit test with a push-out vector per request.
// ----------------------------------------------------------------------------
module circle_collision_pushout #(
   parameter int COORD_WIDTH = ccp_pkg::COORD_WIDTH,
   parameter int FRAC_BITS   = ccp_pkg::FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_cmd,
   input  logic signed [COORD_WIDTH-1:0] req_p_x,
   input  logic signed [COORD_WIDTH-1:0] req_p_y,
   input  logic [COORD_WIDTH-2:0]        req_p_radius,
   input  logic signed [COORD_WIDTH-1:0] req_q_x,
   input  logic signed [COORD_WIDTH-1:0] req_q_y,
   input  logic [COORD_WIDTH-2:0]        req_q_radius,
   input  logic signed [COORD_WIDTH-1:0] req_box_left,
   input  logic signed [COORD_WIDTH-1:0] req_box_right,
   input  logic signed [COORD_WIDTH-1:0] req_box_top,
   input  logic signed [COORD_WIDTH-1:0] req_box_bottom,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic signed [COORD_WIDTH+1:0] rsp_push_x,
   output logic signed [COORD_WIDTH+1:0] rsp_push_y
);

   localparam int W      = COORD_WIDTH;
   localparam int SQ_SW  = 3 * W + 4;
   localparam int DIV_SW = W + 4;

   logic           f_valid, f_hit, f_near, f_sx, f_sy;
   logic [2*W-1:0] f_dsq;
   logic [W-1:0]   f_ax, f_ay, f_r;

   logic             s_valid;
   logic [W-1:0]     s_root;
   logic [SQ_SW-1:0] s_side;

   logic           s_hit, s_near, s_sx, s_sy;
   logic [W-1:0]   s_ax, s_ay, s_r;

   logic           m1_v_ff, m1_hit_ff, m1_near_ff, m1_sx_ff, m1_sy_ff;
   logic [W-1:0]   m1_ax_ff, m1_ay_ff, m1_r_ff, m1_dist_ff, m1_ov_ff;
   logic [W-1:0]   m1_ov_in;

   logic           m2_v_ff, m2_hit_ff, m2_near_ff, m2_sx_ff, m2_sy_ff;
   logic [W-1:0]   m2_r_ff, m2_dist_ff;
   logic [2*W-1:0] m2_pa_ff, m2_pb_ff, m2_pa_in, m2_pb_in;

   logic              d_valid;
   logic [W-1:0]      d_qa, d_qb;
   logic [DIV_SW-1:0] d_side;
   logic              d_hit, d_near, d_sx, d_sy;
   logic [W-1:0]      d_r;

   logic signed [W+1:0] px_in, py_in, mx, my;
   logic                o_v_ff, o_hit_ff;
   logic signed [W+1:0] o_px_ff, o_py_ff;

   assign busy = 1'b0;

   ccp_front #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .cmd       (req_cmd),
      .p_x       (req_p_x),
      .p_y       (req_p_y),
      .p_radius  (req_p_radius),
      .q_x       (req_q_x),
      .q_y       (req_q_y),
      .q_radius  (req_q_radius),
      .box_left  (req_box_left),
      .box_right (req_box_right),
      .box_top   (req_box_top),
      .box_bottom(req_box_bottom),
      .out_valid (f_valid),
      .out_dsq   (f_dsq),
      .out_hit   (f_hit),
      .out_near  (f_near),
      .out_sx    (f_sx),
      .out_sy    (f_sy),
      .out_ax    (f_ax),
      .out_ay    (f_ay),
      .out_r     (f_r)
   );

   ccp_sqrt #(
      .N     (W),
      .SIDE_W(SQ_SW)
   ) u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (f_valid),
      .in_radicand(f_dsq),
      .in_side    ({f_hit, f_near, f_sx, f_sy, f_ax, f_ay, f_r}),
      .out_valid  (s_valid),
      .out_root   (s_root),
      .out_side   (s_side)
   );

   assign {s_hit, s_near, s_sx, s_sy, s_ax, s_ay, s_r} = s_side;

   assign m1_ov_in = s_r - s_root;
   assign m2_pa_in = m1_ax_ff * m1_ov_ff;
   assign m2_pb_in = m1_ay_ff * m1_ov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         o_v_ff  <= 1'b0;
      end else begin
         m1_v_ff <= s_valid;
         m2_v_ff <= m1_v_ff;
         o_v_ff  <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      m1_hit_ff  <= s_hit;
      m1_near_ff <= s_near;
      m1_sx_ff   <= s_sx;
      m1_sy_ff   <= s_sy;
      m1_ax_ff   <= s_ax;
      m1_ay_ff   <= s_ay;
      m1_r_ff    <= s_r;
      m1_dist_ff <= s_root;
      m1_ov_ff   <= m1_ov_in;
      m2_hit_ff  <= m1_hit_ff;
      m2_near_ff <= m1_near_ff;
      m2_sx_ff   <= m1_sx_ff;
      m2_sy_ff   <= m1_sy_ff;
      m2_r_ff    <= m1_r_ff;
      m2_dist_ff <= m1_dist_ff;
      m2_pa_ff   <= m2_pa_in;
      m2_pb_ff   <= m2_pb_in;
   end

   ccp_div #(
      .N     (W),
      .SIDE_W(DIV_SW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m2_v_ff),
      .in_num_a  (m2_pa_ff),
      .in_num_b  (m2_pb_ff),
      .in_divisor(m2_dist_ff),
      .in_side   ({m2_hit_ff, m2_near_ff, m2_sx_ff, m2_sy_ff, m2_r_ff}),
      .out_valid (d_valid),
      .out_quot_a(d_qa),
      .out_quot_b(d_qb),
      .out_side  (d_side)
   );

   assign {d_hit, d_near, d_sx, d_sy, d_r} = d_side;

   always_comb begin
      mx = $signed({2'b00, d_qa});
      my = $signed({2'b00, d_qb});
      if (!d_hit) begin
         px_in = '0;
         py_in = '0;
      end else if (d_near) begin
         px_in = $signed({2'b00, d_r});
         py_in = '0;
      end else begin
         px_in = d_sx ? -mx : mx;
         py_in = d_sy ? -my : my;
      end
   end

   always_ff @(posedge clock) begin
      o_hit_ff <= d_hit;
      o_px_ff  <= px_in;
      o_py_ff  <= py_in;
   end

   assign rsp_valid  = o_v_ff;
   assign rsp_hit    = o_hit_ff;
   assign rsp_push_x = o_px_ff;
   assign rsp_push_y = o_py_ff;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Circle collision push-out testbench
// Drives circle-circle, circle-box, box-box and unused-code requests, directed then random,
// predicts hit and push-out per request and checks each result in order.
// ----------------------------------------------------------------------------
module tb;

   localparam int CW = ccp_pkg::COORD_WIDTH;
   localparam int PW = ccp_pkg::COORD_WIDTH + 2;
   localparam logic [1:0] CMD_BOX_BOX = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam longint NEAR_ZERO_SQ = (64'd1 << (2 * ccp_pkg::FRAC_BITS)) / 64'd100000000;
   localparam int LATENCY = 2 * CW + 7;

   typedef struct packed {
      logic [1:0]           cmd;
      logic signed [CW-1:0] p_x, p_y;
      logic [CW-2:0]        p_radius;
      logic signed [CW-1:0] q_x, q_y;
      logic [CW-2:0]        q_radius;
      logic signed [CW-1:0] box_left, box_right, box_top, box_bottom;
   } pair_type;

   typedef struct packed {
      logic                 hit;
      logic signed [PW-1:0] push_x, push_y;
   } contact_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   pair_type req = '0;
   logic rsp_valid, rsp_hit;
   logic signed [PW-1:0] rsp_push_x, rsp_push_y;

   pair_type pending_pairs[$];
   contact_type expected_contacts[$];
   int mismatches = 0;
   int hits_seen = 0;
   int contacts_seen = 0;
   int gap = 0;
   bit stimulus_done = 1'b0;
   bit drain_hold = 1'b0;

   circle_collision_pushout dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req.cmd), .req_p_x(req.p_x), .req_p_y(req.p_y),
      .req_p_radius(req.p_radius), .req_q_x(req.q_x), .req_q_y(req.q_y),
      .req_q_radius(req.q_radius), .req_box_left(req.box_left),
      .req_box_right(req.box_right), .req_box_top(req.box_top),
      .req_box_bottom(req.box_bottom), .rsp_valid(rsp_valid), .rsp_hit(rsp_hit),
      .rsp_push_x(rsp_push_x), .rsp_push_y(rsp_push_y)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bit_pos;
      root = 0;
      bit_pos = 64'd1 << 62;
      while (bit_pos > n) bit_pos >>= 2;
      while (bit_pos != 0) begin
         if (n >= root + bit_pos) begin
            n -= root + bit_pos;
            root = (root >> 1) + bit_pos;
         end else begin
            root >>= 1;
         end
         bit_pos >>= 2;
      end
      return root;
   endfunction

   function automatic contact_type resolve_offset(longint dx, longint dy,
                                                  longint unsigned extent);
      contact_type c;
      longint unsigned ax, ay, dsq, distance, overlap, mx, my;
      c = '0;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      dsq = ax * ax + ay * ay;
      if (dsq > extent * extent) return c;
      c.hit = 1'b1;
      if (dsq > NEAR_ZERO_SQ) begin
         distance = int_sqrt(dsq);
         overlap = extent - distance;
         mx = (ax * overlap) / distance;
         my = (ay * overlap) / distance;
         c.push_x = PW'(dx < 0 ? -longint'(mx) : longint'(mx));
         c.push_y = PW'(dy < 0 ? -longint'(my) : longint'(my));
      end else begin
         c.push_x = PW'(extent);
      end
      return c;
   endfunction

   function automatic contact_type predict_contact(pair_type p);
      longint cx, cy;
      cx = p.p_x;
      cy = p.p_y;
      if (p.cmd == ccp_pkg::CMD_CIRCLE_CIRCLE)
         return resolve_offset(longint'(p.q_x) - p.p_x, longint'(p.q_y) - p.p_y,
                               longint'(p.p_radius) + p.q_radius);
      if (p.cmd == ccp_pkg::CMD_CIRCLE_BOX) begin
         if (p.p_x < p.box_left) cx = p.box_left;
         else if (p.p_x > p.box_right) cx = p.box_right;
         if (p.p_y < p.box_top) cy = p.box_top;
         else if (p.p_y > p.box_bottom) cy = p.box_bottom;
         return resolve_offset(longint'(p.p_x) - cx, longint'(p.p_y) - cy,
                               p.p_radius);
      end
      return '0;
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      logic [9*32-1:0] raw;
      int span, radius_max, sel;
      logic signed [CW-1:0] a, b;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
      p = raw[$bits(pair_type)-1:0];
      sel = $urandom_range(0, 9);
      p.cmd = sel < 4 ? ccp_pkg::CMD_CIRCLE_CIRCLE : sel < 8 ? ccp_pkg::CMD_CIRCLE_BOX :
              sel == 8 ? CMD_BOX_BOX : CMD_UNUSED;
      if ($urandom_range(0, 9) < 8) begin
         span = 1 << $urandom_range(4, CW - 3);
         radius_max = span;
         p.p_radius = (CW-1)'($urandom_range(0, radius_max));
         p.q_radius = (CW-1)'($urandom_range(0, radius_max));
         p.q_x = CW'(p.p_x + $signed($urandom_range(0, 4 * span)) - 2 * span);
         p.q_y = CW'(p.p_y + $signed($urandom_range(0, 4 * span)) - 2 * span);
         if ($urandom_range(0, 9) == 0) begin
            p.q_x = CW'(p.p_x + $signed($urandom_range(0, 2)) - 1);
            p.q_y = p.p_y;
         end
         a = CW'(p.p_x + $signed($urandom_range(0, 4 * span)) - 2 * span);
         b = CW'(a + $urandom_range(0, 2 * span));
         p.box_left = a;
         p.box_right = b < a ? a : b;
         a = CW'(p.p_y + $signed($urandom_range(0, 4 * span)) - 2 * span);
         b = CW'(a + $urandom_range(0, 2 * span));
         p.box_top = a;
         p.box_bottom = b < a ? a : b;
      end
      return p;
   endfunction

   function automatic pair_type circle_pair(int px, int py, int pr, int qx, int qy, int qr);
      pair_type p;
      p = '0;
      p.cmd = ccp_pkg::CMD_CIRCLE_CIRCLE;
      p.p_x = CW'(px); p.p_y = CW'(py); p.p_radius = (CW-1)'(pr);
      p.q_x = CW'(qx); p.q_y = CW'(qy); p.q_radius = (CW-1)'(qr);
      return p;
   endfunction

   function automatic pair_type box_pair(int px, int py, int pr, int l, int r, int t, int b);
      pair_type p;
      p = '0;
      p.cmd = ccp_pkg::CMD_CIRCLE_BOX;
      p.p_x = CW'(px); p.p_y = CW'(py); p.p_radius = (CW-1)'(pr);
      p.box_left = CW'(l); p.box_right = CW'(r); p.box_top = CW'(t);
      p.box_bottom = CW'(b);
      return p;
   endfunction

   initial begin
      localparam int MAXC = (1 << (CW - 1)) - 1;
      localparam int MINC = -(1 << (CW - 1));
      localparam int MAXR = (1 << (CW - 1)) - 1;
      pair_type p;
      pending_pairs.push_back(circle_pair(0, 0, 4096, 4096, 0, 4096));
      pending_pairs.push_back(circle_pair(0, 0, 4096, 8192, 0, 4096));
      pending_pairs.push_back(circle_pair(0, 0, 4096, 8193, 0, 4096));
      pending_pairs.push_back(circle_pair(100, 100, 500, 100, 100, 300));
      pending_pairs.push_back(circle_pair(0, 0, 10, 1, 0, 0));
      pending_pairs.push_back(circle_pair(MINC, MINC, MAXR, MAXC, MAXC, MAXR));
      pending_pairs.push_back(circle_pair(MAXC, MINC, MAXR, MINC, MAXC, MAXR));
      pending_pairs.push_back(circle_pair(-3000, 2000, 0, -3000, 2000, 0));
      pending_pairs.push_back(circle_pair(MAXC, MAXC, MAXR, MAXC - 5, MAXC - 7, MAXR));
      pending_pairs.push_back(box_pair(0, 0, 4096, 1000, 9000, -500, 500));
      pending_pairs.push_back(box_pair(500, 0, 4096, 0, 1000, -500, 500));
      pending_pairs.push_back(box_pair(-5000, -5000, 4096, -1000, 1000, -1000, 1000));
      pending_pairs.push_back(box_pair(0, 0, 4096, 4096, 5000, 0, 0));
      pending_pairs.push_back(box_pair(0, 0, 10, 1000, 0, 50, -50));
      pending_pairs.push_back(box_pair(MINC, MAXC, MAXR, MAXC, MAXC, MINC, MINC));
      pending_pairs.push_back(box_pair(MAXC, MINC, 0, MINC, MINC, MAXC, MAXC));
      p = circle_pair(0, 0, MAXR, 0, 0, MAXR);
      p.cmd = CMD_BOX_BOX;
      pending_pairs.push_back(p);
      p.cmd = CMD_UNUSED;
      pending_pairs.push_back(p);
      p = '1;
      p.cmd = ccp_pkg::CMD_CIRCLE_CIRCLE;
      pending_pairs.push_back(p);
      p.cmd = ccp_pkg::CMD_CIRCLE_BOX;
      pending_pairs.push_back(p);
      for (int i = 0; i < 880; i++) pending_pairs.push_back(random_pair());
   end

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) pending_pairs.pop_front();
         if (pending_pairs.size() == 450 && !drain_hold) drain_hold = 1'b1;
         if (drain_hold && expected_contacts.size() == 0) drain_hold = 1'b0;
         if (gap > 0 || drain_hold || pending_pairs.size() == 0) begin
            if (gap > 0) gap = gap - 1;
            start <= 1'b0;
            if (pending_pairs.size() == 0) stimulus_done = 1'b1;
         end else begin
            start <= 1'b1;
            req <= pending_pairs[0];
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0) gap = 0;
         end
      end
   end

   always @(posedge clock) begin
      contact_type got, want;
      if (!reset && start && !busy) expected_contacts.push_back(predict_contact(req));
      if (!reset && rsp_valid) begin
         got = {rsp_hit, rsp_push_x, rsp_push_y};
         contacts_seen++;
         if (rsp_hit) hits_seen++;
         if (expected_contacts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result hit=%0b", rsp_hit);
         end else begin
            want = expected_contacts.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Result %0d: expected hit=%0b push=(%0d,%0d) got hit=%0b push=(%0d,%0d)",
                           contacts_seen, want.hit, want.push_x, want.push_y,
                           got.hit, got.push_x, got.push_y);
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b1;
      @(negedge clock);
      reset = 1'b0;
      wait (stimulus_done);
      @(posedge clock);
      while (expected_contacts.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Checked %0d results, %0d of them hits, across all pair kinds.",
               contacts_seen, hits_seen);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Mismatches found");
      $finish;
   end
endmodule
